>>> src/plel_pkg.sv
`timescale 1ns / 1ps
package plel_pkg;

   localparam int MAX_BINS_DEF = 32;

   localparam int ENERGY_W = 20;
   localparam int EFF_W    = 16;
   localparam int INDEX_W  = 5;
   localparam int ACTION_W = 2;
   localparam int COUNT_W  = 6;
   localparam int CONST_W  = 16;

   // shared divider: 37-bit dividend covers both the 32-bit wavelength
   // conversion and the 36-bit interpolation product
   localparam int DIV_W     = 37;
   localparam int DIV_CNT_W = 6;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
   localparam logic [EFF_W-1:0]    EFF_MAX    = '1;

   localparam logic [ACTION_W-1:0] ACT_LOAD_ENERGY  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_WAVE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY_ENERGY = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY_WAVE   = 2'd3;

   localparam logic CSR_BIN_COUNT = 1'b0;
   localparam logic CSR_CONV_CONST = 1'b1;

   localparam logic [COUNT_W-1:0] BIN_COUNT_RESET  = 6'd20;
   localparam logic [CONST_W-1:0] CONV_CONST_RESET = 16'd19890;

   typedef struct packed {
      logic                is_load;
      logic                by_wavelength;
      logic [INDEX_W-1:0]  entry_index;
      logic [EFF_W-1:0]    entry_efficiency;
      logic [ENERGY_W-1:0] photon_value;
   } item_type;

   typedef struct packed {
      logic                start;
      logic [DIV_W-1:0]    dividend;
      logic [ENERGY_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> src/plel_front.sv
`timescale 1ns / 1ps
module plel_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [plel_pkg::ACTION_W-1:0] req_action,
   input  logic [plel_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [plel_pkg::EFF_W-1:0]    req_entry_efficiency,
   input  logic [plel_pkg::ENERGY_W-1:0] req_photon_value,
   output logic                        head_valid,
   output plel_pkg::item_type          head_item,
   input  logic                        head_pop
);
   import plel_pkg::*;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item;
   logic       push;
   logic       pop;

   always_comb begin
      item.is_load          = (req_action == ACT_LOAD_ENERGY) || (req_action == ACT_LOAD_WAVE);
      item.by_wavelength    = (req_action == ACT_LOAD_WAVE) || (req_action == ACT_QUERY_WAVE);
      item.entry_index      = req_entry_index;
      item.entry_efficiency = req_entry_efficiency;
      item.photon_value     = req_photon_value;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> src/plel_div.sv
`timescale 1ns / 1ps
module plel_div (
   input  logic                  clock,
   input  logic                  reset,
   input  plel_pkg::div_req_type div_req,
   output plel_pkg::div_rsp_type div_rsp
);
   import plel_pkg::*;

   logic [DIV_W-1:0]     dq_ff;
   logic [ENERGY_W:0]    rem_ff;
   logic [ENERGY_W-1:0]  dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [ENERGY_W:0]    rem_sh;
   logic [ENERGY_W+1:0]  diff;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      rem_sh = {rem_ff[ENERGY_W-1:0], dq_ff[DIV_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dq_ff  <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
         cnt_ff <= DIV_CNT_W'(DIV_W);
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[DIV_W-2:0], ~diff[ENERGY_W+1]};
         rem_ff <= diff[ENERGY_W+1] ? rem_sh : diff[ENERGY_W:0];
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

>>> src/plel_back.sv
`timescale 1ns / 1ps
module plel_back #(
   parameter int MAX_BINS = plel_pkg::MAX_BINS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [plel_pkg::COUNT_W-1:0]  bin_count,
   input  logic [plel_pkg::CONST_W-1:0]  conv_const,
   input  logic                          head_valid,
   input  plel_pkg::item_type            head_item,
   output logic                          head_pop,
   output plel_pkg::div_req_type         div_req,
   input  plel_pkg::div_rsp_type         div_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plel_pkg::EFF_W-1:0]    rsp_efficiency,
   output logic [plel_pkg::ENERGY_W-1:0] rsp_photon_energy,
   output logic                          rsp_in_range,
   output logic                          rsp_bad_wavelength,
   output logic                          rsp_flat_bin
);
   import plel_pkg::*;

   localparam int AW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
   localparam int CW = $clog2(MAX_BINS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CONV     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_TOP      = 4'd3;
   localparam logic [3:0] S_CMP      = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_DIVST    = 4'd6;
   localparam logic [3:0] S_DIV      = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0] state_ff, state_in;

   logic [ENERGY_W-1:0] energy_mem [MAX_BINS];
   logic [EFF_W-1:0]    eff_mem    [MAX_BINS];
   logic [ENERGY_W-1:0] rd_e_ff;
   logic [EFF_W-1:0]    rd_q_ff;
   logic [AW-1:0]       addr_ff, addr_in;
   logic                mem_we;

   item_type            item_ff;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic                bad_ff, bad_in;
   logic [ENERGY_W-1:0] hi_e_ff, lo_e_ff;
   logic [EFF_W-1:0]    hi_q_ff, lo_q_ff;
   logic                neg_ff;
   logic [DIV_W-1:0]    mag_ff;
   logic [EFF_W-1:0]    eff_ff, eff_in;
   logic                hit_ff, hit_in;
   logic                flat_ff, flat_in;

   logic [CW-1:0]           n_bins;
   logic                    match;
   logic                    idx_ok;
   logic signed [EFF_W:0]   dq;
   logic signed [ENERGY_W:0] de;
   logic signed [EFF_W+ENERGY_W+1:0] prod;
   logic signed [EFF_W+1:0] sum;
   logic                    rsp_load;

   always_comb begin
      if (32'(bin_count) > 32'(MAX_BINS)) begin
         n_bins = CW'(MAX_BINS);
      end else begin
         n_bins = CW'(bin_count);
      end
   end

   assign match  = (energy_ff >= rd_e_ff) && (energy_ff <= hi_e_ff);
   assign idx_ok = 32'(item_ff.entry_index) < 32'(MAX_BINS);
   assign dq     = $signed({1'b0, hi_q_ff}) - $signed({1'b0, lo_q_ff});
   assign de     = $signed({1'b0, energy_ff - lo_e_ff});
   assign prod   = dq * de;
   assign sum    = neg_ff ? $signed({2'b00, lo_q_ff}) - $signed({1'b0, div_rsp.quotient[EFF_W:0]})
                          : $signed({2'b00, lo_q_ff}) + $signed({1'b0, div_rsp.quotient[EFF_W:0]});
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      energy_in = energy_ff;
      bad_in    = bad_ff;
      eff_in    = eff_ff;
      hit_in    = hit_ff;
      flat_in   = flat_ff;
      head_pop  = 1'b0;
      mem_we    = 1'b0;
      div_req   = '0;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               hit_in   = 1'b0;
               flat_in  = 1'b0;
               eff_in   = '0;
               bad_in   = head_item.by_wavelength && (head_item.photon_value == '0);
               if (head_item.by_wavelength && head_item.photon_value != '0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'({conv_const, 16'h0000});
                  div_req.divisor  = head_item.photon_value;
                  state_in         = S_CONV;
               end else begin
                  energy_in = head_item.by_wavelength ? '0 : head_item.photon_value;
                  state_in  = S_DISPATCH;
               end
            end
         end
         S_CONV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIV_W'(ENERGY_MAX)) begin
                  energy_in = ENERGY_MAX;
               end else begin
                  energy_in = div_rsp.quotient[ENERGY_W-1:0];
               end
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (item_ff.is_load) begin
               mem_we   = idx_ok;
               state_in = S_IDLE;
            end else if (n_bins < CW'(2)) begin
               state_in = S_DONE;
            end else begin
               addr_in  = AW'(n_bins - CW'(1));
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            addr_in  = addr_ff - AW'(1);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (match) begin
               hit_in = 1'b1;
               if (rd_e_ff == hi_e_ff) begin
                  flat_in  = 1'b1;
                  eff_in   = rd_q_ff;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end else if (addr_ff == '0) begin
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff - AW'(1);
            end
         end
         S_MUL: begin
            state_in = S_DIVST;
         end
         S_DIVST: begin
            div_req.start    = 1'b1;
            div_req.dividend = mag_ff;
            div_req.divisor  = hi_e_ff - lo_e_ff;
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (sum < 0) begin
                  eff_in = '0;
               end else if (sum > $signed({2'b00, EFF_MAX})) begin
                  eff_in = EFF_MAX;
               end else begin
                  eff_in = sum[EFF_W-1:0];
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         item_ff <= head_item;
      end
      addr_ff   <= addr_in;
      energy_ff <= energy_in;
      bad_ff    <= bad_in;
      eff_ff    <= eff_in;
      hit_ff    <= hit_in;
      flat_ff   <= flat_in;
      if (state_ff == S_TOP || (state_ff == S_CMP && !match)) begin
         hi_e_ff <= rd_e_ff;
         hi_q_ff <= rd_q_ff;
      end
      if (state_ff == S_CMP) begin
         lo_e_ff <= rd_e_ff;
         lo_q_ff <= rd_q_ff;
      end
      if (state_ff == S_MUL) begin
         neg_ff <= prod < 0;
         mag_ff <= (prod < 0) ? DIV_W'(-prod) : DIV_W'(prod);
      end
      if (rsp_load) begin
         rsp_efficiency     <= eff_ff;
         rsp_photon_energy  <= energy_ff;
         rsp_in_range       <= hit_ff;
         rsp_bad_wavelength <= bad_ff;
         rsp_flat_bin       <= flat_ff;
      end
   end

   // read data follows the next address so that one bin is compared a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         energy_mem[AW'(item_ff.entry_index)] <= energy_ff;
         eff_mem[AW'(item_ff.entry_index)]    <= item_ff.entry_efficiency;
      end
      rd_e_ff <= energy_mem[addr_in];
      rd_q_ff <= eff_mem[addr_in];
   end

endmodule

>>> src/piecewise_linear_efficiency_lookup_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | action, entry_index, entry_efficiency, photon_value
// rsp     | out       | rsp_valid/rsp_stall | efficiency, photon_energy, in_range, bad_wavelength, flat_bin
// csr     | in        | csr_valid/csr_ready | index, data
//
// One item at a time in the back end. A load or query by wavelength first converts the
// value in the shared 37-step restoring divider; a query then scans the table one bin a
// cycle, and an interpolation uses the same divider once more.
// Reset is synchronous; table contents are undefined until loaded.
// A two-entry queue takes req beats while the back end works or rsp is stalled, until it is full.
module piecewise_linear_efficiency_lookup_core #(
   parameter int MAX_BINS = plel_pkg::MAX_BINS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [plel_pkg::ACTION_W-1:0] req_action,
   input  logic [plel_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [plel_pkg::EFF_W-1:0]    req_entry_efficiency,
   input  logic [plel_pkg::ENERGY_W-1:0] req_photon_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plel_pkg::EFF_W-1:0]    rsp_efficiency,
   output logic [plel_pkg::ENERGY_W-1:0] rsp_photon_energy,
   output logic                          rsp_in_range,
   output logic                          rsp_bad_wavelength,
   output logic                          rsp_flat_bin,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [plel_pkg::CONST_W-1:0]  csr_data
);
   import plel_pkg::*;

   logic [COUNT_W-1:0] bin_count_ff;
   logic [CONST_W-1:0] conv_const_ff;
   logic               head_valid;
   item_type           head_item;
   logic               head_pop;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff  <= BIN_COUNT_RESET;
         conv_const_ff <= CONV_CONST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BIN_COUNT:  bin_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_CONV_CONST: conv_const_ff <= csr_data;
            default: ;
         endcase
      end
   end

   plel_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_entry_efficiency (req_entry_efficiency),
      .req_photon_value     (req_photon_value),
      .head_valid           (head_valid),
      .head_item            (head_item),
      .head_pop             (head_pop)
   );

   plel_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   plel_back #(
      .MAX_BINS (MAX_BINS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .bin_count          (bin_count_ff),
      .conv_const         (conv_const_ff),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .head_pop           (head_pop),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_efficiency     (rsp_efficiency),
      .rsp_photon_energy  (rsp_photon_energy),
      .rsp_in_range       (rsp_in_range),
      .rsp_bad_wavelength (rsp_bad_wavelength),
      .rsp_flat_bin       (rsp_flat_bin)
   );

endmodule

>>> src/plel_checker.sv
`timescale 1ns / 1ps
module plel_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [plel_pkg::EFF_W-1:0]    rsp_efficiency,
   input logic [plel_pkg::ENERGY_W-1:0] rsp_photon_energy,
   input logic                          rsp_in_range,
   input logic                          rsp_bad_wavelength,
   input logic                          rsp_flat_bin
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_efficiency))
      else $error("result beat changed while stalled");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_efficiency == '0)
      else $error("efficiency nonzero with no bracketing pair");

   a_flat_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flat_bin |-> rsp_in_range)
      else $error("flat pair reported out of range");

   a_bad_wave_energy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_wavelength |-> rsp_photon_energy == '0)
      else $error("zero wavelength gave nonzero energy");

endmodule

bind piecewise_linear_efficiency_lookup_core plel_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_efficiency     (rsp_efficiency),
   .rsp_photon_energy  (rsp_photon_energy),
   .rsp_in_range       (rsp_in_range),
   .rsp_bad_wavelength (rsp_bad_wavelength),
   .rsp_flat_bin       (rsp_flat_bin)
);

>>> test/tb_piecewise_linear_efficiency_lookup_core.sv
`timescale 1ns / 1ps
module tb_piecewise_linear_efficiency_lookup_core;
   import plel_pkg::*;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  index;
      logic [EFF_W-1:0]    eff;
      logic [ENERGY_W-1:0] value;
   } beat_t;

   typedef struct {
      logic [EFF_W-1:0]    eff;
      logic [ENERGY_W-1:0] energy;
      logic                in_range;
      logic                bad_wl;
      logic                flat;
   } lookup_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic [EFF_W-1:0]    req_entry_efficiency = '0;
   logic [ENERGY_W-1:0] req_photon_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [EFF_W-1:0]    rsp_efficiency;
   logic [ENERGY_W-1:0] rsp_photon_energy;
   logic                rsp_in_range;
   logic                rsp_bad_wavelength;
   logic                rsp_flat_bin;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_BIN_COUNT;
   logic [CONST_W-1:0]  csr_data = '0;

   beat_t   pending_beats[$];
   lookup_t expected_lookups[$];
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   logic    req_taken = 1'b0;
   logic    holdoff_req = 1'b0;
   logic    holdoff_done = 1'b0;
   int      holdoff_cnt = 0;

   logic [ENERGY_W-1:0] energy_tab[MAX_BINS_DEF];
   logic [EFF_W-1:0]    eff_tab[MAX_BINS_DEF];
   logic [COUNT_W-1:0]  bins_cfg = BIN_COUNT_RESET;
   logic [CONST_W-1:0]  conv_cfg = CONV_CONST_RESET;

   piecewise_linear_efficiency_lookup_core dut (.*);

   always #4 clock = ~clock;

   function automatic logic [ENERGY_W-1:0] wl_to_energy(logic [ENERGY_W-1:0] wl);
      longint unsigned q;
      if (wl == 0) return '0;
      q = ({48'd0, conv_cfg} << 16) / wl;
      if (q > ENERGY_MAX) q = ENERGY_MAX;
      return q[ENERGY_W-1:0];
   endfunction

   function automatic lookup_t predict_lookup(beat_t b);
      lookup_t r;
      int n;
      longint q1, q2, v;
      r.bad_wl = (b.action == ACT_QUERY_WAVE) && (b.value == 0);
      r.energy = (b.action == ACT_QUERY_WAVE) ? wl_to_energy(b.value) : b.value;
      r.eff = '0;
      r.in_range = 1'b0;
      r.flat = 1'b0;
      n = (bins_cfg > MAX_BINS_DEF) ? MAX_BINS_DEF : bins_cfg;
      for (int i = n - 1; i > 0; i--) begin
         if (r.energy >= energy_tab[i-1] && r.energy <= energy_tab[i]) begin
            q1 = eff_tab[i-1];
            q2 = eff_tab[i];
            r.in_range = 1'b1;
            if (energy_tab[i-1] == energy_tab[i]) begin
               v = q1;
               r.flat = 1'b1;
            end else begin
               v = q1 + ((q2 - q1) * longint'(r.energy - energy_tab[i-1]))
                      / longint'(energy_tab[i] - energy_tab[i-1]);
            end
            if (v < 0) v = 0;
            if (v > EFF_MAX) v = EFF_MAX;
            r.eff = v[EFF_W-1:0];
            break;
         end
      end
      return r;
   endfunction

   // predictor and result checker
   always @(posedge clock) begin
      beat_t   b;
      lookup_t e;
      req_taken <= req_valid && !req_stall;
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_BIN_COUNT) bins_cfg = csr_data[COUNT_W-1:0];
         else conv_cfg = csr_data;
      end
      if (!reset && req_valid && !req_stall) begin
         b = '{req_action, req_entry_index, req_entry_efficiency, req_photon_value};
         if (b.action == ACT_LOAD_ENERGY || b.action == ACT_LOAD_WAVE) begin
            energy_tab[b.index] = (b.action == ACT_LOAD_WAVE) ? wl_to_energy(b.value)
                                                             : b.value;
            eff_tab[b.index] = b.eff;
         end else begin
            expected_lookups.push_back(predict_lookup(b));
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result beat eff=%h energy=%h", $time,
                     rsp_efficiency, rsp_photon_energy);
            mismatches++;
         end else begin
            e = expected_lookups.pop_front();
            if (rsp_efficiency !== e.eff) begin
               $display("%0t: efficiency exp %h got %h", $time, e.eff, rsp_efficiency);
               mismatches++;
            end
            if (rsp_photon_energy !== e.energy) begin
               $display("%0t: photon_energy exp %h got %h", $time, e.energy,
                        rsp_photon_energy);
               mismatches++;
            end
            if (rsp_in_range !== e.in_range) begin
               $display("%0t: in_range exp %b got %b", $time, e.in_range, rsp_in_range);
               mismatches++;
            end
            if (rsp_bad_wavelength !== e.bad_wl) begin
               $display("%0t: bad_wavelength exp %b got %b", $time, e.bad_wl,
                        rsp_bad_wavelength);
               mismatches++;
            end
            if (rsp_flat_bin !== e.flat) begin
               $display("%0t: flat_bin exp %b got %b", $time, e.flat, rsp_flat_bin);
               mismatches++;
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      beat_t b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_action <= b.action;
            req_entry_index <= b.index;
            req_entry_efficiency <= b.eff;
            req_photon_value <= b.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_req && !holdoff_done) begin
         holdoff_done <= 1'b1;
         holdoff_cnt <= 600;
         rsp_stall <= 1'b1;
      end else if (holdoff_cnt > 0) begin
         holdoff_cnt <= holdoff_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_beat(logic [ACTION_W-1:0] a, int idx, int eff, int val);
      beat_t b;
      b.action = a;
      b.index = idx[INDEX_W-1:0];
      b.eff = eff[EFF_W-1:0];
      b.value = val[ENERGY_W-1:0];
      pending_beats.push_back(b);
   endtask

   task automatic write_csr(logic idx, logic [CONST_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_beats.size() > 0 || req_valid || expected_lookups.size() > 0)
         @(posedge clock);
      // loads leave no result; let the back end settle
      repeat (200) @(posedge clock);
   endtask

   // ascending table over the bins in use, occasionally with flat pairs
   task automatic load_ramp(int n, output int lo, output int hi);
      int e;
      int span;
      span = $urandom_range(3) == 0 ? 32'hFFFFF / 32 : 4096;
      e = $urandom_range(span);
      lo = e;
      for (int i = 0; i < n; i++) begin
         push_beat(ACT_LOAD_ENERGY, i, $urandom_range(16'hFFFF), e);
         hi = e;
         if ($urandom_range(7) != 0) e += $urandom_range(span);
      end
   endtask

   initial begin
      int lo, hi, n, cnt, t, wl;
      longint lw;
      int bins_set[6];
      int conv_set[6];
      bins_set = '{20, 2, 32, 63, 1, 0};
      conv_set = '{19890, 1, 65535, 12345, 777, 40000};
      for (int i = 0; i < MAX_BINS_DEF; i++) begin
         energy_tab[i] = '0;
         eff_tab[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every bin so that no query reads an unwritten entry
      for (int i = 0; i < MAX_BINS_DEF; i++)
         push_beat(ACT_LOAD_ENERGY, i, i == 3 ? 16'hFFFF : i * 1999, i * 32768);
      push_beat(ACT_LOAD_ENERGY, 5, 16'hFFFF, 4 * 32768);
      push_beat(ACT_LOAD_WAVE, 0, 0, 0);
      push_beat(ACT_LOAD_WAVE, 31, 16'hFFFF, 20'hFFFFF);
      push_beat(ACT_QUERY_ENERGY, 0, 0, 0);
      push_beat(ACT_QUERY_ENERGY, 31, 16'hFFFF, 20'hFFFFF);
      push_beat(ACT_QUERY_ENERGY, 0, 0, 3 * 32768 + 100);
      push_beat(ACT_QUERY_ENERGY, 0, 0, 4 * 32768);
      push_beat(ACT_QUERY_ENERGY, 0, 0, 2 * 32768 + 12345);
      push_beat(ACT_QUERY_WAVE, 0, 0, 0);
      push_beat(ACT_QUERY_WAVE, 0, 0, 1);
      push_beat(ACT_QUERY_WAVE, 0, 0, 20'hFFFFF);
      push_beat(ACT_QUERY_WAVE, 0, 0, 16 * 1000);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_BIN_COUNT, {10'($urandom_range(1023)), 6'(bins_set[p])});
         write_csr(CSR_CONV_CONST, 16'(conv_set[p]));
         send_idle_pct = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 11 : 0;
         stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 11 : 0;
         n = bins_set[p] > MAX_BINS_DEF ? MAX_BINS_DEF : (bins_set[p] < 2 ? 2 : bins_set[p]);
         cnt = 0;
         while (cnt < 180) begin
            load_ramp(n, lo, hi);
            cnt += n;
            for (int q = 0; q < 20; q++) begin
               t = $urandom_range(9);
               if (t < 5) begin
                  push_beat(ACT_QUERY_ENERGY, 0, 0, $urandom_range(hi, lo));
               end else if (t < 7) begin
                  t = $urandom_range(hi, lo);
                  lw = t == 0 ? 0 : ((longint'(conv_set[p]) << 16) / t);
                  if (lw > 20'hFFFFF) lw = 20'hFFFFF;
                  wl = int'(lw);
                  push_beat(ACT_QUERY_WAVE, 0, 0, wl + $urandom_range(2) - 1);
               end else begin
                  // noise: any action, any field value
                  push_beat(2'($urandom_range(3)), $urandom_range(31),
                            $urandom_range(16'hFFFF), $urandom_range(20'hFFFFF));
               end
               cnt++;
            end
            if (p == 0 && cnt > 100) holdoff_req = 1'b1;
         end
         drain();
      end

      if (mismatches == 0 && expected_lookups.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
